FILE: rtl/pts_pkg.sv
`timescale 1ns / 1ps

package pts_pkg;

   localparam int OP_W      = 2;
   localparam int STATUS_W  = 2;
   localparam int UID_W     = 8;
   localparam int HANDLER_W = 8;
   localparam int TIME_W    = 32;

   localparam int MAX_RESULTS = 16;
   localparam int FIRE_CNT_W  = $clog2(MAX_RESULTS + 1);

   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_RUN    = 2'd2,
      OP_FORCE  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_NOTFOUND = 2'd2
   } status_type;

   typedef struct packed {
      logic [UID_W-1:0]     uid;
      logic [HANDLER_W-1:0] handler;
      logic [TIME_W-1:0]    period;
      logic [TIME_W-1:0]    last_time;
   } slot_type;

   typedef struct packed {
      status_type           status;
      logic                 fired;
      logic [UID_W-1:0]     uid;
      logic [HANDLER_W-1:0] handler;
      logic                 last;
   } result_type;

endpackage

FILE: rtl/pts_req_if.sv
`timescale 1ns / 1ps

interface pts_req_if
   import pts_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      op;
   logic [HANDLER_W-1:0] handler_code;
   logic [TIME_W-1:0]    task_period;
   logic [UID_W-1:0]     task_uid;
   logic [TIME_W-1:0]    now_ms;

   modport source (
      output valid, op, handler_code, task_period, task_uid, now_ms,
      input  ready
   );

   modport sink (
      input  valid, op, handler_code, task_period, task_uid, now_ms,
      output ready
   );
endinterface

FILE: rtl/pts_rsp_if.sv
`timescale 1ns / 1ps

interface pts_rsp_if
   import pts_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic                 fired;
   logic [UID_W-1:0]     result_uid;
   logic [HANDLER_W-1:0] result_handler;
   logic                 last_result;

   modport source (
      output valid, status, fired, result_uid, result_handler, last_result,
      input  ready
   );

   modport sink (
      input  valid, status, fired, result_uid, result_handler, last_result,
      output ready
   );
endinterface

FILE: rtl/pts_slot_ram.sv
`timescale 1ns / 1ps

module pts_slot_ram
   import pts_pkg::*;
#(
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  slot_type      wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output slot_type      rd_data
);

   slot_type mem [DEPTH];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/periodic_task_scheduler_top.sv
`timescale 1ns / 1ps

// Periodic task scheduler.
// req_bus carries one command per beat: add, remove, run tick or force.
// rsp_bus returns one or more beats per command; last_result marks the
// final beat of a command. Run and force emit one beat per fired task
// (at most 16 per command) or a single beat with fired low when none fires.
// One command is taken at a time; req_bus.ready is high only while idle.
// Steps, from accept to the final beat entering the output register:
//   add:           one write of the new task into the slot at the table end
//   remove:        scan from slot 0 until found, then move the last slot into its place
//   run / force:   scan the stored tasks, stopping once 16 have fired
// The slot table is a single-port-read memory, so each slot visited is read in S_SCAN
// and checked in S_CHECK through the shared hit comparator (time for run, uid for force).
// Firings are held one deep so the last one can carry last_result; a
// stalled rsp_bus holds the scan at the next firing until the beat drains.
// The output register lets a new command be accepted while the last beat
// of the previous one still waits.
// Synchronous reset empties the table and sets the next id to one; no
// clearing pass is needed.

module periodic_task_scheduler_top
   import pts_pkg::*;
#(
   parameter int TASK_SLOTS = 16
) (
   input  logic     clock,
   input  logic     reset,
   pts_req_if.sink  req_bus,
   pts_rsp_if.source rsp_bus
);

   localparam int AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CW = $clog2(TASK_SLOTS + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_SCAN,
      S_CHECK,
      S_MOVE_RD,
      S_MOVE_WR,
      S_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [UID_W-1:0]       next_uid_ff, next_uid_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [FIRE_CNT_W-1:0]  fire_cnt_ff, fire_cnt_in;
   logic                   pend_valid_ff, pend_valid_in;
   result_type             pend_ff, pend_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_ff, rsp_in;

   op_type                 op_ff, op_in;
   logic [HANDLER_W-1:0]   handler_ff, handler_in;
   logic [TIME_W-1:0]      period_ff, period_in;
   logic [UID_W-1:0]       uid_ff, uid_in;
   logic [TIME_W-1:0]      now_ff, now_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   slot_type               wr_data;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   slot_type               rd_data;

   logic                   out_free;
   logic                   hit;
   logic [TIME_W-1:0]      elapsed;
   logic [CW-1:0]          last_cnt;
   result_type             idle_result;

   pts_slot_ram #(
      .DEPTH (TASK_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign elapsed  = now_ff - rd_data.last_time;
   assign last_cnt = count_ff - CW'(1);

   always_comb begin
      if (op_ff == OP_FORCE) begin
         hit = (rd_data.uid == uid_ff);
      end else begin
         hit = (elapsed >= rd_data.period);
      end
   end

   always_comb begin
      idle_result         = '0;
      idle_result.status  = ((op_ff == OP_REMOVE) || (op_ff == OP_FORCE)) ? ST_NOTFOUND : ST_OK;
      idle_result.last    = 1'b1;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      next_uid_in   = next_uid_ff;
      idx_in        = idx_ff;
      fire_cnt_in   = fire_cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_in        = rsp_ff;
      op_in         = op_ff;
      handler_in    = handler_ff;
      period_in     = period_ff;
      uid_in        = uid_ff;
      now_in        = now_ff;

      wr_en   = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_data = rd_data;
      rd_en   = 1'b0;
      rd_addr = idx_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               op_in         = op_type'(req_bus.op);
               handler_in    = req_bus.handler_code;
               period_in     = req_bus.task_period;
               uid_in        = req_bus.task_uid;
               now_in        = req_bus.now_ms;
               idx_in        = '0;
               fire_cnt_in   = '0;
               pend_valid_in = 1'b0;
               state_in      = (op_type'(req_bus.op) == OP_ADD) ? S_ADD : S_SCAN;
            end
         end

         S_ADD: begin
            pend_in       = '0;
            pend_valid_in = 1'b1;
            if (count_ff == CW'(TASK_SLOTS)) begin
               pend_in.status = ST_FULL;
            end else begin
               wr_en             = 1'b1;
               wr_addr           = count_ff[AW-1:0];
               wr_data.uid       = next_uid_ff;
               wr_data.handler   = handler_ff;
               wr_data.period    = period_ff;
               wr_data.last_time = '0;
               count_in          = count_ff + CW'(1);
               next_uid_in       = next_uid_ff + UID_W'(1);
               pend_in.status    = ST_OK;
               pend_in.uid       = next_uid_ff;
            end
            state_in = S_FINISH;
         end

         S_SCAN: begin
            if ((idx_ff == count_ff) || (fire_cnt_ff == FIRE_CNT_W'(MAX_RESULTS))) begin
               state_in = S_FINISH;
            end else begin
               rd_en    = 1'b1;
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            if (op_ff == OP_REMOVE) begin
               if (rd_data.uid == uid_ff) begin
                  state_in = S_MOVE_RD;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = S_SCAN;
               end
            end else if (!hit) begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_SCAN;
            end else if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = pend_ff;
               end
               pend_in.status    = ST_OK;
               pend_in.fired     = 1'b1;
               pend_in.uid       = rd_data.uid;
               pend_in.handler   = rd_data.handler;
               pend_in.last      = 1'b0;
               pend_valid_in     = 1'b1;
               wr_en             = 1'b1;
               wr_data.last_time = now_ff;
               fire_cnt_in       = fire_cnt_ff + FIRE_CNT_W'(1);
               idx_in            = idx_ff + CW'(1);
               state_in          = S_SCAN;
            end
         end

         S_MOVE_RD: begin
            rd_en    = 1'b1;
            rd_addr  = last_cnt[AW-1:0];
            state_in = S_MOVE_WR;
         end

         S_MOVE_WR: begin
            wr_en          = 1'b1;
            count_in       = last_cnt;
            pend_in        = '0;
            pend_in.status = ST_OK;
            pend_in.uid    = uid_ff;
            pend_valid_in  = 1'b1;
            state_in       = S_FINISH;
         end

         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (pend_valid_ff) begin
                  rsp_in      = pend_ff;
                  rsp_in.last = 1'b1;
               end else begin
                  rsp_in = idle_result;
               end
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         next_uid_ff   <= UID_W'(1);
         idx_ff        <= '0;
         fire_cnt_ff   <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         next_uid_ff   <= next_uid_in;
         idx_ff        <= idx_in;
         fire_cnt_ff   <= fire_cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_ff    <= pend_in;
      rsp_ff     <= rsp_in;
      op_ff      <= op_in;
      handler_ff <= handler_in;
      period_ff  <= period_in;
      uid_ff     <= uid_in;
      now_ff     <= now_in;
   end

   assign req_bus.ready          = (state_ff == S_IDLE);
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = rsp_ff.status;
   assign rsp_bus.fired          = rsp_ff.fired;
   assign rsp_bus.result_uid     = rsp_ff.uid;
   assign rsp_bus.result_handler = rsp_ff.handler;
   assign rsp_bus.last_result    = rsp_ff.last;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench
   import pts_pkg::*;
();

   localparam int TASK_SLOTS   = 16;
   localparam int RANDOM_ITEMS = 400;
   localparam int HOLD_CYCLES  = 400;
   localparam int QUIET_LIMIT  = 4000;
   localparam int TAIL_CYCLES  = 60;

   typedef struct {
      op_type      op;
      logic [7:0]  handler;
      logic [31:0] period;
      logic [7:0]  uid;
      logic [31:0] now;
      int          send_idle;
      int          recv_stall;
      bit          drain;
      bit          hold;
   } sched_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pts_req_if req_bus ();
   pts_rsp_if rsp_bus ();

   periodic_task_scheduler_top #(.TASK_SLOTS(TASK_SLOTS)) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // task table as the scheduler should hold it
   logic [7:0]  tbl_uid     [TASK_SLOTS];
   logic [7:0]  tbl_handler [TASK_SLOTS];
   logic [31:0] tbl_period  [TASK_SLOTS];
   logic [31:0] tbl_last    [TASK_SLOTS];
   int          tbl_count = 0;
   logic [7:0]  uid_counter = 8'd1;

   sched_cmd_type cmd_q [$];
   result_type  pending_rsp_q [$];
   sched_cmd_type cur;
   bit          have_cur = 1'b0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          hold_reqs = 0;
   int          holds_taken = 0;
   int          hold_left = 0;
   int          fail_count = 0;
   int          quiet_cycles = 0;

   // shadow of the table contents used only to steer stimulus
   logic [7:0]  gen_ids [$];
   logic [7:0]  gen_uid = 8'd1;

   function automatic result_type beat(status_type st, logic fired, logic [7:0] uid,
                                       logic [7:0] handler, logic last);
      result_type r;
      r.status  = st;
      r.fired   = fired;
      r.uid     = uid;
      r.handler = handler;
      r.last    = last;
      return r;
   endfunction

   function automatic void predict_scheduler(input sched_cmd_type c);
      int          hits [$];
      int          found;
      int          tail;
      logic [31:0] elapsed;
      bit          hit;
      found = -1;
      case (c.op)
         OP_ADD: begin
            if (tbl_count >= TASK_SLOTS) begin
               pending_rsp_q.push_back(beat(ST_FULL, 1'b0, 8'd0, 8'd0, 1'b1));
            end else begin
               tbl_uid[tbl_count]     = uid_counter;
               tbl_handler[tbl_count] = c.handler;
               tbl_period[tbl_count]  = c.period;
               tbl_last[tbl_count]    = 32'd0;
               tbl_count++;
               pending_rsp_q.push_back(beat(ST_OK, 1'b0, uid_counter, 8'd0, 1'b1));
               uid_counter = uid_counter + 8'd1;
            end
         end
         OP_REMOVE: begin
            for (int k = 0; k < tbl_count; k++) begin
               if (found < 0 && tbl_uid[k] == c.uid) found = k;
            end
            if (found >= 0) begin
               tail = tbl_count - 1;
               tbl_uid[found]     = tbl_uid[tail];
               tbl_handler[found] = tbl_handler[tail];
               tbl_period[found]  = tbl_period[tail];
               tbl_last[found]    = tbl_last[tail];
               tbl_uid[tail]      = 8'd0;
               tbl_handler[tail]  = 8'd0;
               tbl_period[tail]   = 32'd0;
               tbl_last[tail]     = 32'd0;
               tbl_count = tail;
               pending_rsp_q.push_back(beat(ST_OK, 1'b0, c.uid, 8'd0, 1'b1));
            end else begin
               pending_rsp_q.push_back(beat(ST_NOTFOUND, 1'b0, 8'd0, 8'd0, 1'b1));
            end
         end
         default: begin
            for (int k = 0; k < tbl_count && hits.size() < MAX_RESULTS; k++) begin
               elapsed = c.now - tbl_last[k];
               if (c.op == OP_FORCE) hit = (tbl_uid[k] == c.uid);
               else hit = (elapsed >= tbl_period[k]);
               if (hit) begin
                  tbl_last[k] = c.now;
                  hits.push_back(k);
               end
            end
            if (hits.size() == 0) begin
               pending_rsp_q.push_back(beat((c.op == OP_FORCE) ? ST_NOTFOUND : ST_OK,
                                            1'b0, 8'd0, 8'd0, 1'b1));
            end else begin
               for (int j = 0; j < hits.size(); j++) begin
                  pending_rsp_q.push_back(beat(ST_OK, 1'b1, tbl_uid[hits[j]],
                                               tbl_handler[hits[j]], j == hits.size() - 1));
               end
            end
         end
      endcase
   endfunction

   task automatic queue_cmd(input op_type op, input logic [7:0] handler,
                            input logic [31:0] period, input logic [7:0] uid,
                            input logic [31:0] now, input int si, input int rs,
                            input bit drain, input bit hold);
      sched_cmd_type c;
      c.op = op;
      c.handler = handler;
      c.period = period;
      c.uid = uid;
      c.now = now;
      c.send_idle = si;
      c.recv_stall = rs;
      c.drain = drain;
      c.hold = hold;
      cmd_q.push_back(c);
      if (op == OP_ADD && gen_ids.size() < TASK_SLOTS) begin
         gen_ids.push_back(gen_uid);
         gen_uid = gen_uid + 8'd1;
      end else if (op == OP_REMOVE) begin
         foreach (gen_ids[k]) begin
            if (gen_ids[k] == uid) begin
               gen_ids.delete(k);
               break;
            end
         end
      end
   endtask

   always @(posedge clock) begin : driver
      logic offer;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_scheduler(cur);
            have_cur = 1'b0;
         end
         if (!have_cur && cmd_q.size() > 0 &&
             !(cmd_q[0].drain && pending_rsp_q.size() != 0)) begin
            cur = cmd_q.pop_front();
            have_cur = 1'b1;
            send_idle_pct = cur.send_idle;
            recv_stall_pct = cur.recv_stall;
            if (cur.hold) hold_reqs++;
         end
         offer = have_cur && ((req_bus.valid && !req_bus.ready) ||
                              $urandom_range(0, 99) >= send_idle_pct);
         req_bus.valid <= offer;
         if (offer) begin
            req_bus.op           <= cur.op;
            req_bus.handler_code <= cur.handler;
            req_bus.task_period  <= cur.period;
            req_bus.task_uid     <= cur.uid;
            req_bus.now_ms       <= cur.now;
         end
      end
   end

   always @(posedge clock) begin : monitor
      result_type want;
      result_type got;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = beat(status_type'(rsp_bus.status), rsp_bus.fired, rsp_bus.result_uid,
                       rsp_bus.result_handler, rsp_bus.last_result);
            if (pending_rsp_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("ERROR: unexpected beat st=%0d fired=%0d uid=%0d hdl=%0d last=%0d",
                           got.status, got.fired, got.uid, got.handler, got.last);
            end else begin
               want = pending_rsp_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("ERROR: expected st=%0d fired=%0d uid=%0d hdl=%0d last=%0d, %s",
                              want.status, want.fired, want.uid, want.handler, want.last,
                              $sformatf("got st=%0d fired=%0d uid=%0d hdl=%0d last=%0d",
                                        got.status, got.fired, got.uid, got.handler,
                                        got.last));
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
         end else if (hold_reqs != holds_taken) begin
            hold_left = HOLD_CYCLES;
            holds_taken++;
         end
         rsp_bus.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      int          n;
      int          pick;
      int          cnt;
      int          si;
      int          rs;
      op_type      op;
      logic [31:0] period;
      logic [7:0]  uid;
      logic [31:0] now;
      logic [31:0] gen_time;

      req_bus.valid = 1'b0;
      req_bus.op = OP_ADD;
      req_bus.handler_code = '0;
      req_bus.task_period = '0;
      req_bus.task_uid = '0;
      req_bus.now_ms = '0;
      rsp_bus.ready = 1'b0;

      // empty table: nothing due, unknown ids
      queue_cmd(OP_RUN, 8'h00, 32'h0, 8'h00, 32'h0, 0, 0, 1'b0, 1'b0);
      queue_cmd(OP_FORCE, 8'h12, 32'h5, 8'h5A, 32'h10, 0, 0, 1'b0, 1'b0);
      queue_cmd(OP_REMOVE, 8'h00, 32'h0, 8'h01, 32'h0, 0, 0, 1'b0, 1'b0);
      // fill the table, zero and maximum periods first
      queue_cmd(OP_ADD, 8'hFF, 32'h0, 8'h00, 32'h0, 0, 0, 1'b0, 1'b0);
      queue_cmd(OP_ADD, 8'h00, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 0, 0, 1'b0, 1'b0);
      for (int k = 0; k < TASK_SLOTS - 2; k++) begin
         period = (k == 0) ? 32'h8000_0000 : $urandom_range(1, 900);
         queue_cmd(OP_ADD, 8'($urandom_range(0, 255)), period, 8'($urandom_range(0, 255)),
                   $urandom, 0, 0, 1'b0, 1'b0);
      end
      queue_cmd(OP_ADD, 8'hA5, 32'h10, 8'h00, 32'h0, 0, 0, 1'b0, 1'b0);
      // every slot due, then only period zero, then across the time wrap
      queue_cmd(OP_RUN, 8'h00, 32'h0, 8'h00, 32'hFFFF_FFFF, 0, 0, 1'b0, 1'b0);
      queue_cmd(OP_RUN, 8'h00, 32'h0, 8'h00, 32'hFFFF_FFFF, 0, 0, 1'b0, 1'b0);
      queue_cmd(OP_RUN, 8'h00, 32'h0, 8'h00, 32'h5, 0, 0, 1'b0, 1'b0);
      queue_cmd(OP_FORCE, 8'h00, 32'h0, 8'h02, 32'h1234_5678, 0, 0, 1'b0, 1'b0);
      queue_cmd(OP_REMOVE, 8'h00, 32'h0, 8'h01, 32'h0, 0, 0, 1'b0, 1'b0);
      queue_cmd(OP_REMOVE, 8'h00, 32'h0, 8'h09, 32'h0, 0, 0, 1'b1, 1'b0);

      gen_time = 32'd100;
      n = 0;
      while (n < RANDOM_ITEMS) begin
         case ((n / 50) % 4)
            0: begin si = 0;  rs = 0;  end
            1: begin si = 77; rs = 0;  end
            2: begin si = 0;  rs = 77; end
            default: begin si = 10; rs = 10; end
         endcase
         cnt = gen_ids.size();
         pick = $urandom_range(0, 99);
         if (cnt >= TASK_SLOTS)
            op = (pick < 12) ? OP_ADD : (pick < 70) ? OP_REMOVE : (pick < 90) ? OP_RUN : OP_FORCE;
         else if (cnt < 3)
            op = (pick < 70) ? OP_ADD : (pick < 80) ? OP_REMOVE : (pick < 92) ? OP_RUN : OP_FORCE;
         else
            op = (pick < 48) ? OP_ADD : (pick < 84) ? OP_REMOVE : (pick < 94) ? OP_RUN : OP_FORCE;
         if (n == 40) op = OP_RUN;

         pick = $urandom_range(0, 99);
         if (pick < 10) period = 32'd0;
         else if (pick < 25) period = $urandom;
         else period = $urandom_range(1, 900);

         if (cnt > 0 && $urandom_range(0, 99) < 75) uid = gen_ids[$urandom_range(0, cnt - 1)];
         else uid = 8'($urandom_range(0, 255));

         if ($urandom_range(0, 99) < 12) gen_time = $urandom;
         else gen_time = gen_time + $urandom_range(0, 500);
         now = gen_time;

         queue_cmd(op, 8'($urandom_range(0, 255)), period, uid, now, si, rs,
                   (n % 97) == 96, n == 40);
         n++;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (cmd_q.size() != 0 || have_cur || pending_rsp_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_rsp_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
